// ----- rtl/golomb_encoder_assert.svh -----
// Assertion macros for the encoder top file, golomb_encoder.sv.
// Both sample on the rising edge of clk; the checked form is disabled in reset.
`ifndef GOLOMB_ENCODER_ASSERT_SVH
`define GOLOMB_ENCODER_ASSERT_SVH

// Check a property outside reset.
`define GLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define GLE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/gle_pkg.sv -----
// ----------------------------------------------------------------------------
// gle_pkg
// Shared widths and the structs between the Golomb encoder blocks.
// ----------------------------------------------------------------------------
package gle_pkg;

  localparam int DIV_W  = 16;             // value, divisor, quotient, remainder
  localparam int CNT_W  = $clog2(DIV_W);  // divider step counter
  localparam int LEN_W  = 5;              // suffix length and ceil-log2
  localparam int CODE_W = 32;             // code_chunk field
  localparam int BITS_W = 6;              // chunk_bits field

  // Divider result, valid for one cycle with done
  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DIV_W-1:0] rem;
    logic [LEN_W-1:0] clog;
  } div_res_t;

  // Load command for the bit serializer
  typedef struct packed {
    logic             load;
    logic             flag;
    logic [DIV_W-1:0] unary;
    logic [DIV_W-1:0] sfx;
    logic [LEN_W-1:0] len;
  } ser_load_t;

endpackage

// ----- rtl/golomb_encoder.sv -----
// ----------------------------------------------------------------------------
// golomb_encoder
// Golomb encoder with truncated-binary remainder, emitting the code as chunks.
//
//   channel  dir  handshake            payload
//   in_      in   in_tvalid/in_tready  tdata: value
//   out_     out  out_tvalid/out_tready tdata: code_chunk, chunk_bits;
//                                      tlast: last_chunk; tuser: too_long
//   cfg_     in   cfg_wr_en            cfg_wr_data: divisor
//
// One item at a time: the serial divider runs its 16 bit steps and raises done,
// the suffix is formed in S_CALC, then the serializer shifts out one code bit
// per cycle (q + 1 + suffix length bits) while its output slot is free, or one
// empty chunk for a flagged item, and the FSM returns to idle before the next
// input transfer. A chunk stalled in the output register by out_tready
// holds the serializer. Reset sets divisor to 1 and clears all control state.
// ----------------------------------------------------------------------------
module golomb_encoder
  import gle_pkg::*;
#(
  parameter int VALUE_WIDTH  = 16,
  parameter int CHUNK_WIDTH  = 32,
  parameter int MAX_QUOTIENT = 1023
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // [31:0] code_chunk, [37:32] chunk_bits, [39:38] zero
  output logic        out_tlast,
  output logic        out_tuser,   // [0] too_long
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int VW_EFF    = (VALUE_WIDTH > DIV_W) ? DIV_W : VALUE_WIDTH;
  localparam int EFF_CHUNK = (CHUNK_WIDTH > CODE_W) ? CODE_W : CHUNK_WIDTH;
  localparam int CODE_MAX  = 64 * EFF_CHUNK;
  localparam logic [DIV_W-1:0] VMASK = DIV_W'((32'd1 << VW_EFF) - 32'd1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_CALC = 2'd2;
  localparam logic [1:0] S_SER  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [DIV_W-1:0]  divisor_r;
  logic              in_xfer;
  div_res_t          div_res;
  div_res_t          res_r;
  ser_load_t         ser_cmd;
  logic              ser_busy;
  logic [CODE_W-1:0] o_chunk;
  logic [BITS_W-1:0] o_bits;
  logic [DIV_W:0]    pow_b;
  logic [DIV_W:0]    u_off;
  logic [DIV_W:0]    sfx_w;
  logic [LEN_W-1:0]  len_c;
  logic [DIV_W:0]    total;
  logic              too_long;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  // Hold the divisor register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divisor_r <= DIV_W'(1);
    end else if (cfg_wr_en) begin
      divisor_r <= cfg_wr_data;
    end
  end

  gle_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (in_xfer),
    .dividend_i(in_tdata & VMASK),
    .divisor_i (divisor_r),
    .res_o     (div_res)
  );

  // Capture the quotient, remainder and ceil-log2
  always_ff @(posedge clk) begin
    if (div_res.done) begin
      res_r <= div_res;
    end
  end

  // Truncated-binary suffix and the too-long check
  always_comb begin
    pow_b = (DIV_W+1)'(1) << res_r.clog;
    u_off = pow_b - {1'b0, divisor_r};
    if ({1'b0, res_r.rem} >= u_off) begin
      len_c = res_r.clog;
      sfx_w = {1'b0, res_r.rem} + u_off;
    end else begin
      len_c = res_r.clog - LEN_W'(1);
      sfx_w = {1'b0, res_r.rem};
    end
    total    = {1'b0, res_r.quot} + (DIV_W+1)'(1) + (DIV_W+1)'(len_c);
    too_long = (divisor_r == '0) || (res_r.quot > DIV_W'(MAX_QUOTIENT))
               || (total > (DIV_W+1)'(CODE_MAX));
  end

  assign ser_cmd.load  = (state_r == S_CALC);
  assign ser_cmd.flag  = too_long;
  assign ser_cmd.unary = res_r.quot;
  assign ser_cmd.sfx   = sfx_w[DIV_W-1:0];
  assign ser_cmd.len   = len_c;

  // Sequence one item: divide, form the suffix, serialize
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_xfer) state_nxt = S_DIV;
      S_DIV:   if (div_res.done) state_nxt = S_CALC;
      S_CALC:  state_nxt = S_SER;
      S_SER:   if (!ser_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  gle_serializer #(
    .CHUNK_BITS(EFF_CHUNK)
  ) u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_i      (ser_cmd),
    .busy_o     (ser_busy),
    .out_valid_o(out_tvalid),
    .out_ready_i(out_tready),
    .out_chunk_o(o_chunk),
    .out_bits_o (o_bits),
    .out_last_o (out_tlast),
    .out_flag_o (out_tuser)
  );

  assign out_tdata = {2'b00, o_bits, o_chunk};

  // Checks
`include "golomb_encoder_assert.svh"

  `GLE_ASSERT(a_flag_shape, out_tvalid && out_tuser |-> out_tlast && out_tdata[37:32] == 6'd0, "flagged result must be an empty last chunk")
  `GLE_ASSERT(a_chunk_size, out_tvalid && !out_tuser |-> out_tdata[37:32] != 6'd0 && out_tdata[37:32] <= 6'(EFF_CHUNK), "code chunk size out of range")
  `GLE_ASSERT(a_div_in_div, div_res.done |-> state_r == S_DIV, "divider finished outside the divide phase")
  `GLE_ASSERT(a_one_item, in_tvalid && in_tready |=> !in_tready, "input accepted while an item is in flight")

endmodule

// ----- rtl/gle_divider.sv -----
// ----------------------------------------------------------------------------
// gle_divider
// Restoring divider, one quotient bit per cycle, with a ceil-log2 scan of the
// divisor running alongside.
// ----------------------------------------------------------------------------
module gle_divider
  import gle_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output div_res_t         res_o
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] dvd_r, dvd_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] mm1_r, mm1_nxt;
  logic [LEN_W-1:0] clog_r, clog_nxt;
  logic             found_r, found_nxt;
  logic [DIV_W:0]   rem_t;
  logic [DIV_W:0]   rem_sub;
  logic             ge;

  // One restoring step and one scan step per cycle
  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    mm1_nxt   = mm1_r;
    clog_nxt  = clog_r;
    found_nxt = found_r;
    rem_t     = {rem_r, dvd_r[DIV_W-1]};
    ge        = rem_t >= {1'b0, divisor_i};
    rem_sub   = rem_t - {1'b0, divisor_i};
    if (start_i) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      dvd_nxt   = dividend_i;
      rem_nxt   = '0;
      quo_nxt   = '0;
      mm1_nxt   = divisor_i - DIV_W'(1);
      clog_nxt  = '0;
      found_nxt = 1'b0;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sub[DIV_W-1:0] : rem_t[DIV_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      dvd_nxt = {dvd_r[DIV_W-2:0], 1'b0};
      mm1_nxt = {mm1_r[DIV_W-2:0], 1'b0};
      // bit length of divisor-1 is the first set bit seen from the top
      if (mm1_r[DIV_W-1] && !found_r) begin
        clog_nxt  = LEN_W'(DIV_W) - LEN_W'(cnt_r);
        found_nxt = 1'b1;
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r   <= cnt_nxt;
    dvd_r   <= dvd_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    mm1_r   <= mm1_nxt;
    clog_r  <= clog_nxt;
    found_r <= found_nxt;
  end

  assign res_o.done = done_r;
  assign res_o.quot = quo_r;
  assign res_o.rem  = rem_r;
  assign res_o.clog = clog_r;

endmodule

// ----- rtl/gle_serializer.sv -----
// ----------------------------------------------------------------------------
// gle_serializer
// Shifts the code out one bit per cycle, while the output slot is free, into a
// chunk register and hands full or final chunks to the output register.
// ----------------------------------------------------------------------------
module gle_serializer
  import gle_pkg::*;
#(
  parameter int CHUNK_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ser_load_t         cmd_i,
  output logic              busy_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CODE_W-1:0] out_chunk_o,
  output logic [BITS_W-1:0] out_bits_o,
  output logic              out_last_o,
  output logic              out_flag_o
);

  logic [DIV_W-1:0]  unary_r, unary_nxt;
  logic              term_r, term_nxt;
  logic [DIV_W-1:0]  sfx_r, sfx_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              flag_r, flag_nxt;
  logic [CODE_W-1:0] chunk_r, chunk_nxt;
  logic [BITS_W-1:0] cnt_r, cnt_nxt;
  logic              ov_r, ov_nxt;
  logic [CODE_W-1:0] oc_r, oc_nxt;
  logic [BITS_W-1:0] ob_r, ob_nxt;
  logic              ol_r, ol_nxt;
  logic              of_r, of_nxt;
  logic              active;
  logic              slot_free;
  logic              code_bit;
  logic [CODE_W-1:0] chunk_sh;
  logic [BITS_W-1:0] cnt_inc;
  logic              drained;

  assign active    = (unary_r != '0) || term_r || (len_r != '0);
  assign slot_free = !ov_r || out_ready_i;
  assign busy_o    = active || flag_r;

  // Next code bit: unary ones, the terminating zero, then the suffix MSB first
  always_comb begin
    unary_nxt = unary_r;
    term_nxt  = term_r;
    len_nxt   = len_r;
    code_bit  = 1'b0;
    if (unary_r != '0) begin
      code_bit  = 1'b1;
      unary_nxt = unary_r - DIV_W'(1);
    end else if (term_r) begin
      term_nxt = 1'b0;
    end else if (len_r != '0) begin
      len_nxt  = len_r - LEN_W'(1);
      code_bit = sfx_r[len_nxt[CNT_W-1:0]];
    end
    chunk_sh = {chunk_r[CODE_W-2:0], code_bit};
    cnt_inc  = cnt_r + BITS_W'(1);
    drained  = (unary_nxt == '0) && !term_nxt && (len_nxt == '0);
  end

  // Advance one bit when the output slot is free; push full or final chunks
  always_comb begin
    flag_nxt  = flag_r;
    sfx_nxt   = sfx_r;
    chunk_nxt = chunk_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r && !out_ready_i;
    oc_nxt    = oc_r;
    ob_nxt    = ob_r;
    ol_nxt    = ol_r;
    of_nxt    = of_r;
    if (cmd_i.load) begin
      flag_nxt  = cmd_i.flag;
      sfx_nxt   = cmd_i.sfx;
      chunk_nxt = '0;
      cnt_nxt   = '0;
    end else if (slot_free && flag_r) begin
      flag_nxt = 1'b0;
      ov_nxt   = 1'b1;
      oc_nxt   = '0;
      ob_nxt   = '0;
      ol_nxt   = 1'b1;
      of_nxt   = 1'b1;
    end else if (slot_free && active) begin
      if (cnt_inc == BITS_W'(CHUNK_BITS) || drained) begin
        ov_nxt    = 1'b1;
        oc_nxt    = chunk_sh;
        ob_nxt    = cnt_inc;
        ol_nxt    = drained;
        of_nxt    = 1'b0;
        chunk_nxt = '0;
        cnt_nxt   = '0;
      end else begin
        chunk_nxt = chunk_sh;
        cnt_nxt   = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unary_r <= '0;
      term_r  <= 1'b0;
      len_r   <= '0;
      flag_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      ov_r   <= ov_nxt;
      flag_r <= flag_nxt;
      if (cmd_i.load) begin
        // a flagged item carries no code bits
        unary_r <= cmd_i.flag ? '0 : cmd_i.unary;
        term_r  <= !cmd_i.flag;
        len_r   <= cmd_i.flag ? '0 : cmd_i.len;
      end else if (slot_free && active && !flag_r) begin
        unary_r <= unary_nxt;
        term_r  <= term_nxt;
        len_r   <= len_nxt;
      end
    end
    sfx_r   <= sfx_nxt;
    chunk_r <= chunk_nxt;
    cnt_r   <= cnt_nxt;
    oc_r    <= oc_nxt;
    ob_r    <= ob_nxt;
    ol_r    <= ol_nxt;
    of_r    <= of_nxt;
  end

  assign out_valid_o = ov_r;
  assign out_chunk_o = oc_r;
  assign out_bits_o  = ob_r;
  assign out_last_o  = ol_r;
  assign out_flag_o  = of_r;

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: Golomb encoder testbench
// Drives values through the stream input, rewrites the divisor between phases
// while the encoder is idle, and checks every code chunk on the output stream
// against a local encoder model. Both sides idle in random bursts until the two closing phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
  import gle_pkg::*;
();

  localparam int VALUE_WIDTH  = 16;
  localparam int CHUNK_WIDTH  = 32;
  localparam int MAX_QUOTIENT = 1023;
  localparam int CHUNK_LIMIT  = 64;    // most chunks one value may produce
  localparam int NUM_ROWS     = 24;
  localparam int NUM_PHASES   = 14;
  localparam int PHASE_ITEMS  = 14;

  // One output transfer, fields in output order
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [BITS_W-1:0] bits;
    logic              last;
    logic              flag;
  } chunk_t;

  // One directed stimulus row; result is used only when typed is set
  typedef struct packed {
    logic        set_div;
    logic [15:0] div;
    logic [15:0] value;
    logic        typed;
    chunk_t      result;
  } row_t;

  localparam chunk_t FLAGGED = {32'h0, 6'd0, 1'b1, 1'b1};
  localparam chunk_t NONE    = '0;

  localparam row_t DIRECTED [NUM_ROWS] = '{
    // divisor one after reset: unary code only
    {1'b0, 16'd0,     16'd0,     1'b1, {32'h0, 6'd1, 1'b1, 1'b0}},
    {1'b0, 16'd0,     16'd1,     1'b1, {32'h2, 6'd2, 1'b1, 1'b0}},
    {1'b0, 16'd0,     16'd1023,  1'b0, NONE},
    {1'b0, 16'd0,     16'd1024,  1'b1, FLAGGED},
    {1'b0, 16'd0,     16'd65535, 1'b1, FLAGGED},
    // zero divisor flags every value
    {1'b1, 16'd0,     16'd0,     1'b1, FLAGGED},
    {1'b0, 16'd0,     16'd65535, 1'b1, FLAGGED},
    // largest divisor, both suffix lengths
    {1'b1, 16'd65535, 16'd0,     1'b1, {32'h0, 6'd16, 1'b1, 1'b0}},
    {1'b0, 16'd0,     16'd65534, 1'b1, {32'hFFFF, 6'd17, 1'b1, 1'b0}},
    {1'b0, 16'd0,     16'd65535, 1'b1, {32'h10000, 6'd17, 1'b1, 1'b0}},
    // power of two: plain binary remainder
    {1'b1, 16'd32768, 16'd32767, 1'b0, NONE},
    {1'b0, 16'd0,     16'd65535, 1'b0, NONE},
    // divisor three: short and long truncated remainder
    {1'b1, 16'd3,     16'd0,     1'b1, {32'h0, 6'd2, 1'b1, 1'b0}},
    {1'b0, 16'd0,     16'd1,     1'b1, {32'h2, 6'd3, 1'b1, 1'b0}},
    {1'b0, 16'd0,     16'd2,     1'b1, {32'h3, 6'd3, 1'b1, 1'b0}},
    {1'b0, 16'd0,     16'd3069,  1'b0, NONE},
    {1'b0, 16'd0,     16'd3072,  1'b1, FLAGGED},
    // longest accepted code: 33 chunks
    {1'b1, 16'd64,    16'd65535, 1'b0, NONE},
    // quotient right at and just over the limit
    {1'b1, 16'd2,     16'd2047,  1'b0, NONE},
    {1'b0, 16'd0,     16'd2048,  1'b1, FLAGGED},
    {1'b1, 16'd1000,  16'd12345, 1'b0, NONE},
    {1'b1, 16'd4096,  16'hA5A5,  1'b0, NONE},
    {1'b1, 16'd40000, 16'd50000, 1'b0, NONE},
    {1'b1, 16'd1,     16'd0,     1'b1, {32'h0, 6'd1, 1'b1, 1'b0}}
  };

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata    = '0;     // [15:0] value
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [39:0] out_tdata;            // [31:0] code_chunk, [37:32] chunk_bits
  logic        out_tlast;
  logic        out_tuser;            // [0] too_long
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  chunk_t      expected_chunks[$];
  int unsigned divisor_setting = 1;
  int          error_count     = 0;
  bit          steady          = 1'b0;   // no idling in the closing phases

  golomb_encoder #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .CHUNK_WIDTH (CHUNK_WIDTH),
    .MAX_QUOTIENT(MAX_QUOTIENT)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the encoder hangs
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  // Append one chunk to the expected list
  task automatic queue_chunk(input chunk_t c);
    expected_chunks = {expected_chunks, c};
  endtask

  // Queue the chunks that encoding v under the current divisor gives
  task automatic encode_value(input logic [15:0] v);
    int unsigned m, q, r, b, u, len, sfx, total, i;
    logic   nxt;
    chunk_t c;
    m = divisor_setting;
    if (m == 0) begin
      queue_chunk(FLAGGED);
      return;
    end
    q = v / m;
    r = v % m;
    b = 0;
    while ((32'd1 << b) < m) b++;
    if ((32'd1 << b) == m) begin
      len = b;
      sfx = r;
    end else begin
      u = (32'd1 << b) - m;
      if (r < u) begin
        len = b - 1;
        sfx = r;
      end else begin
        len = b;
        sfx = r + u;
      end
    end
    total = q + 1 + len;
    if (q > MAX_QUOTIENT || total > CHUNK_LIMIT * CHUNK_WIDTH) begin
      queue_chunk(FLAGGED);
      return;
    end
    // Walk the code bit by bit: unary ones, stop zero, then the suffix
    c = '0;
    for (i = 0; i < total; i++) begin
      if (i < q) nxt = 1'b1;
      else if (i == q) nxt = 1'b0;
      else nxt = 1'((sfx >> (total - 1 - i)) & 1);
      c.code = {c.code[CODE_W-2:0], nxt};
      c.bits = c.bits + BITS_W'(1);
      if (c.bits == BITS_W'(CHUNK_WIDTH) || i == total - 1) begin
        c.last = (i == total - 1);
        c.flag = 1'b0;
        queue_chunk(c);
        c = '0;
      end
    end
  endtask

  // Hold one value until its transfer, queue its chunks, then maybe idle
  task automatic send_value(input logic [15:0] v, input logic typed, input chunk_t result);
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    if (typed) queue_chunk(result);
    else encode_value(v);
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Drain the encoder, then write a new divisor
  task automatic write_divisor(input logic [15:0] d);
    in_tvalid <= 1'b0;
    while (expected_chunks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= d;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    divisor_setting = d;
  endtask

  // Mostly short codes, some up to the quotient limit, some raw values
  function automatic logic [15:0] pick_value(input int unsigned m);
    int unsigned kind, qlim, q, v;
    kind = $urandom_range(0, 99);
    if (m == 0 || kind >= 85) begin
      v = $urandom_range(0, 65535);
      return v[15:0];
    end
    qlim = (kind < 60) ? 31 : MAX_QUOTIENT;
    if (qlim > 65535 / m) qlim = 65535 / m;
    q = $urandom_range(0, qlim);
    v = q * m + $urandom_range(0, m - 1);
    if (v > 65535) v = v - m;
    return v[15:0];
  endfunction

  // Stall the output in random bursts
  initial begin
    @(posedge clk);
    forever begin
      if (!steady && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Compare each output transfer with the oldest expected chunk
  always @(posedge clk) begin : result_check
    chunk_t got;
    chunk_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[31:0], out_tdata[37:32], out_tlast, out_tuser};
      if (expected_chunks.size() == 0) begin
        note_error($sformatf("unexpected chunk code=%h bits=%0d last=%b flag=%b",
                             got.code, got.bits, got.last, got.flag));
      end else begin
        want = expected_chunks.pop_front();
        if (got !== want)
          note_error($sformatf({"chunk mismatch: expected code=%h bits=%0d last=%b flag=%b,",
                                " got code=%h bits=%0d last=%b flag=%b"},
                               want.code, want.bits, want.last, want.flag,
                               got.code, got.bits, got.last, got.flag));
      end
    end
  end

  initial begin : main_seq
    int          r, p, k;
    row_t        row;
    int unsigned d;
    int unsigned phase_div [12];
    phase_div = '{1, 0, 2, 3, 5, 7, 100, 1000, 4096, 32768, 40000, 65535};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows
    for (r = 0; r < NUM_ROWS; r++) begin
      row = DIRECTED[r];
      if (row.set_div) write_divisor(row.div);
      send_value(row.value, row.typed, row.result);
    end

    // Random phases, one divisor each; the last two run without idling
    for (p = 0; p < NUM_PHASES; p++) begin
      d = (p < 12) ? phase_div[p] : $urandom_range(1, 65535);
      write_divisor(d[15:0]);
      if (p >= NUM_PHASES - 2) steady = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++) send_value(pick_value(d), 1'b0, NONE);
    end

    // Wait out the remaining chunks
    in_tvalid <= 1'b0;
    while (expected_chunks.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/gle_pkg.sv
rtl/gle_divider.sv
rtl/gle_serializer.sv
rtl/golomb_encoder.sv
tb/tb.sv
